>>> rtl/msm_pkg.sv
package msm_pkg;

	localparam int MAX_NODES_D = 256;
	localparam int ALPHABET_D  = 26;
	localparam int MAX_WORDS_D = 16;

	typedef enum logic [1:0] {
		FUNC_PATTERN = 2'd0,
		FUNC_BUILD   = 2'd1,
		FUNC_TEXT    = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NODES_FULL  = 2'd1,
		ST_WORDS_FULL  = 2'd2,
		ST_AFTER_BUILD = 2'd3
	} status_t;

	typedef struct packed {
		func_t      func;
		logic [4:0] symbol;
		logic       end_of_word;
		logic       start_of_text;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic        match_found;
		logic [3:0]  word_id;
		logic [31:0] start_pos;
		logic        last;
	} out_item_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_PAT_CHK,
		CMD_PAT_WR,
		CMD_PAT_OWN,
		CMD_DONE,
		CMD_B_RD,
		CMD_B_CH,
		CMD_B_F1,
		CMD_B_F2,
		CMD_B_NEXT,
		CMD_B_POP,
		CMD_T_RD,
		CMD_T_CK,
		CMD_T_FL,
		CMD_T_NRD,
		CMD_T_SCAN,
		CMD_T_LEN,
		CMD_T_NXT,
		CMD_T_END
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic stop_pat;
		logic pat_nofit;
		logic rd_zero;
		logic cur_b_zero;
		logic c_last;
		logic f_zero;
		logic q_empty;
		logic cur_zero;
		logic n_zero;
		logic own_bit;
		logic w_last;
		logic pend_wait;
		logic out_free;
	} dp_stat_t;

endpackage

>>> rtl/multi_pattern_string_matcher.sv
// channel  | valid        | stall        | payload
// item     | item_valid   | item_stall   | item   (in_item_t)
// result   | result_valid | result_stall | result (out_item_t)
//
// After reset the child table is cleared (MAX_NODES*ALPHABET entries, 6656 by default);
// item_stall stays high until then.
// Pattern item: reads the child entry, adds a node if it is missing, then updates the
// node's word bits. Build: reads each table entry of each node, tries failure links for
// each child and pops each queued node. Text: follows failure links, then scans the word
// bits of each node on the suffix chain; one result per match, or one empty result.
// result_stall holds the result register and halts the item in work.
module multi_pattern_string_matcher import msm_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_D,
	parameter int ALPHABET  = ALPHABET_D,
	parameter int MAX_WORDS = MAX_WORDS_D
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	cmd_t     cmd;
	dp_stat_t stat;
	logic     idle;

	assign item_stall = !idle;

	msm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_func  (item.func),
		.stat       (stat),
		.idle       (idle),
		.cmd        (cmd)
	);

	msm_dp #(
		.MAX_NODES (MAX_NODES),
		.ALPHABET  (ALPHABET),
		.MAX_WORDS (MAX_WORDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.stat         (stat),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

>>> rtl/msm_ctrl.sv
module msm_ctrl import msm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	input  func_t    item_func,
	input  dp_stat_t stat,
	output logic     idle,
	output cmd_t     cmd
);

	typedef enum logic [19:0] {
		S_CLR     = 20'h00001,
		S_IDLE    = 20'h00002,
		S_PAT_CHK = 20'h00004,
		S_PAT_WR  = 20'h00008,
		S_PAT_OWN = 20'h00010,
		S_DONE    = 20'h00020,
		S_B_RD    = 20'h00040,
		S_B_CH    = 20'h00080,
		S_B_F1    = 20'h00100,
		S_B_F2    = 20'h00200,
		S_B_NEXT  = 20'h00400,
		S_B_POP   = 20'h00800,
		S_T_RD    = 20'h01000,
		S_T_CK    = 20'h02000,
		S_T_FL    = 20'h04000,
		S_T_NRD   = 20'h08000,
		S_T_SCAN  = 20'h10000,
		S_T_LEN   = 20'h20000,
		S_T_NXT   = 20'h40000,
		S_T_END   = 20'h80000
	} state_t;

	state_t state_q, state_d;

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = CMD_NONE;
		case (state_q)
			S_CLR: begin
				cmd = CMD_CLEAR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (item_valid) begin
					cmd = CMD_LOAD;
					case (item_func)
						FUNC_PATTERN: state_d = S_PAT_CHK;
						FUNC_BUILD:   state_d = S_B_RD;
						FUNC_TEXT:    state_d = S_T_RD;
						default:      state_d = S_DONE;
					endcase
				end
			end
			S_PAT_CHK: begin
				cmd = CMD_PAT_CHK;
				state_d = stat.stop_pat ? S_DONE : S_PAT_WR;
			end
			S_PAT_WR: begin
				cmd = CMD_PAT_WR;
				state_d = stat.pat_nofit ? S_DONE : S_PAT_OWN;
			end
			S_PAT_OWN: begin
				cmd = CMD_PAT_OWN;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd = CMD_DONE;
				if (stat.out_free) state_d = S_IDLE;
			end
			S_B_RD: begin
				cmd = CMD_B_RD;
				state_d = S_B_CH;
			end
			S_B_CH: begin
				cmd = CMD_B_CH;
				if (!stat.rd_zero && !stat.cur_b_zero) state_d = S_B_F1;
				else state_d = stat.c_last ? S_B_NEXT : S_B_RD;
			end
			S_B_F1: begin
				cmd = CMD_B_F1;
				state_d = S_B_F2;
			end
			S_B_F2: begin
				cmd = CMD_B_F2;
				if (stat.f_zero || !stat.rd_zero) state_d = stat.c_last ? S_B_NEXT : S_B_RD;
				else state_d = S_B_F1;
			end
			S_B_NEXT: begin
				cmd = CMD_B_NEXT;
				state_d = stat.q_empty ? S_DONE : S_B_POP;
			end
			S_B_POP: begin
				cmd = CMD_B_POP;
				state_d = S_B_RD;
			end
			S_T_RD: begin
				cmd = CMD_T_RD;
				state_d = S_T_CK;
			end
			S_T_CK: begin
				cmd = CMD_T_CK;
				state_d = (!stat.cur_zero && stat.rd_zero) ? S_T_FL : S_T_NRD;
			end
			S_T_FL: begin
				cmd = CMD_T_FL;
				state_d = S_T_RD;
			end
			S_T_NRD: begin
				cmd = CMD_T_NRD;
				state_d = stat.n_zero ? S_T_END : S_T_SCAN;
			end
			S_T_SCAN: begin
				cmd = CMD_T_SCAN;
				if (stat.own_bit) state_d = S_T_LEN;
				else if (stat.w_last) state_d = S_T_NXT;
			end
			S_T_LEN: begin
				cmd = CMD_T_LEN;
				if (!stat.pend_wait) state_d = stat.w_last ? S_T_NXT : S_T_SCAN;
			end
			S_T_NXT: begin
				cmd = CMD_T_NXT;
				state_d = S_T_NRD;
			end
			S_T_END: begin
				cmd = CMD_T_END;
				if (stat.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= state_d;
	end

endmodule

>>> rtl/msm_dp.sv
module msm_dp import msm_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_D,
	parameter int ALPHABET  = ALPHABET_D,
	parameter int MAX_WORDS = MAX_WORDS_D
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  in_item_t  item,
	output dp_stat_t  stat,
	input  logic      result_stall,
	output logic      result_valid,
	output out_item_t result
);

	localparam int NW    = $clog2(MAX_NODES);
	localparam int NCW   = NW + 1;
	localparam int SW    = $clog2(ALPHABET);
	localparam int WW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int WCW   = $clog2(MAX_WORDS + 1);
	localparam int DEPTH = MAX_NODES * ALPHABET;
	localparam int CW    = $clog2(DEPTH);

	logic [NW-1:0]        child_mem [DEPTH];
	logic [NW-1:0]        fail_mem  [MAX_NODES];
	logic [MAX_WORDS-1:0] own_mem   [MAX_NODES];
	logic [NW-1:0]        wl_mem    [MAX_WORDS];
	logic [NW-1:0]        q_mem     [MAX_NODES];

	logic [NW-1:0]        child_rd, fail_rd, wl_rd, q_rd;
	logic [MAX_WORDS-1:0] own_rd;

	func_t          func_q;
	logic [SW-1:0]  sym_q;
	logic           eow_q;
	status_t        st_q;
	logic [NCW-1:0] nc_q;
	logic [WCW-1:0] wc_q;
	logic [NW-1:0]  ins_q, plen_q, nxt_q, cur_q, cur_b_q, ch_q, f_q, n_q;
	logic           fresh_q, failed_q, built_q;
	logic [31:0]    pos_q;
	logic [CW-1:0]  clr_q;
	logic [SW-1:0]  c_q;
	logic [NCW-1:0] head_q, tail_q;
	logic [WW-1:0]  w_q, pend_w_q;
	logic           pend_v_q;
	logic [31:0]    pend_pos_q;
	logic           res_v_q;
	out_item_t      res_q;

	logic           child_re, child_we, fail_re, fail_we, own_re, own_we;
	logic           wl_re, wl_we, q_re, q_we;
	logic [NW-1:0]  c_rnode, fail_raddr, fail_waddr, fail_wdata, own_addr, q_wdata;
	logic [SW-1:0]  c_rsym;
	logic [CW-1:0]  c_waddr;
	logic [NW-1:0]  c_wdata;
	logic [MAX_WORDS-1:0] own_wdata;
	logic           rd0, out_free, emit, fix_ok;
	out_item_t      emit_item;
	logic [32:0]    i_plus, len_x;
	logic [31:0]    match_pos;
	logic [SW-1:0]  sym_in;
	logic [WW+3:0]  wid_x;

	function automatic logic [CW-1:0] caddr(input logic [NW-1:0] nd, input logic [SW-1:0] sy);
		return CW'(nd) * CW'(ALPHABET) + CW'(sy);
	endfunction

	assign rd0      = (child_rd == '0);
	assign out_free = !res_v_q || !result_stall;
	assign fix_ok   = f_q == '0 || !rd0;
	assign sym_in   = (int'(item.symbol) >= ALPHABET) ? SW'(ALPHABET - 1) : SW'(item.symbol);

	assign i_plus    = {1'b0, pos_q} + 33'd1;
	assign len_x     = {{(33 - NW){1'b0}}, wl_rd};
	assign match_pos = (len_x > i_plus && pos_q != '1) ? 32'd0 : 32'(i_plus - len_x);
	assign wid_x     = {4'b0, pend_w_q};

	always_comb begin
		stat.clr_last   = clr_q == CW'(DEPTH - 1);
		stat.stop_pat   = built_q || failed_q || wc_q == WCW'(MAX_WORDS);
		stat.pat_nofit  = rd0 && nc_q == NCW'(MAX_NODES);
		stat.rd_zero    = rd0;
		stat.cur_b_zero = cur_b_q == '0;
		stat.c_last     = c_q == SW'(ALPHABET - 1);
		stat.f_zero     = f_q == '0;
		stat.q_empty    = head_q == tail_q;
		stat.cur_zero   = cur_q == '0;
		stat.n_zero     = n_q == '0;
		stat.own_bit    = own_rd[w_q];
		stat.w_last     = w_q == WW'(MAX_WORDS - 1);
		stat.pend_wait  = pend_v_q && !out_free;
		stat.out_free   = out_free;
	end

	always_comb begin
		child_re = 1'b0; c_rnode = '0; c_rsym = '0;
		child_we = 1'b0; c_waddr = '0; c_wdata = '0;
		fail_re = 1'b0; fail_raddr = '0;
		fail_we = 1'b0; fail_waddr = '0; fail_wdata = '0;
		own_re = 1'b0; own_we = 1'b0; own_addr = '0;
		own_wdata = (fresh_q ? '0 : own_rd) |
			(eow_q ? (MAX_WORDS'(1) << wc_q[WW-1:0]) : '0);
		wl_re = 1'b0; wl_we = 1'b0;
		q_re = 1'b0; q_we = 1'b0; q_wdata = '0;
		case (cmd)
			CMD_CLEAR: begin
				child_we = 1'b1; c_waddr = clr_q;
			end
			CMD_PAT_CHK: begin
				child_re = !stat.stop_pat; c_rnode = ins_q; c_rsym = sym_q;
			end
			CMD_PAT_WR: begin
				child_we = rd0 && !stat.pat_nofit;
				c_waddr = caddr(ins_q, sym_q);
				c_wdata = NW'(nc_q);
				own_re = 1'b1;
				own_addr = rd0 ? NW'(nc_q) : child_rd;
			end
			CMD_PAT_OWN: begin
				own_we = 1'b1; own_addr = nxt_q;
				wl_we = eow_q;
			end
			CMD_B_RD: begin
				child_re = 1'b1; c_rnode = cur_b_q; c_rsym = c_q;
			end
			CMD_B_CH: begin
				fail_re = !rd0 && !stat.cur_b_zero; fail_raddr = cur_b_q;
				fail_we = !rd0 && stat.cur_b_zero; fail_waddr = child_rd;
				q_we = fail_we; q_wdata = child_rd;
			end
			CMD_B_F1: begin
				child_re = 1'b1; c_rnode = fail_rd; c_rsym = c_q;
			end
			CMD_B_F2: begin
				fail_re = !fix_ok; fail_raddr = f_q;
				fail_we = fix_ok; fail_waddr = ch_q; fail_wdata = child_rd;
				q_we = fix_ok; q_wdata = ch_q;
			end
			CMD_B_NEXT: begin
				q_re = !stat.q_empty;
			end
			CMD_T_RD: begin
				child_re = 1'b1; c_rnode = cur_q; c_rsym = sym_q;
			end
			CMD_T_CK: begin
				fail_re = !stat.cur_zero && rd0; fail_raddr = cur_q;
			end
			CMD_T_NRD: begin
				fail_re = !stat.n_zero; fail_raddr = n_q;
				own_re = !stat.n_zero; own_addr = n_q;
			end
			CMD_T_SCAN: begin
				wl_re = stat.own_bit;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (child_we) child_mem[c_waddr] <= c_wdata;
		if (child_re) child_rd <= child_mem[caddr(c_rnode, c_rsym)];
		if (fail_we) fail_mem[fail_waddr] <= fail_wdata;
		if (fail_re) fail_rd <= fail_mem[fail_raddr];
		if (own_we) own_mem[own_addr] <= own_wdata;
		if (own_re) own_rd <= own_mem[own_addr];
		if (wl_we) wl_mem[wc_q[WW-1:0]] <= plen_q + NW'(1);
		if (wl_re) wl_rd <= wl_mem[w_q];
		if (q_we) q_mem[tail_q[NW-1:0]] <= q_wdata;
		if (q_re) q_rd <= q_mem[head_q[NW-1:0]];
	end

	always_comb begin
		emit = 1'b0;
		emit_item = '0;
		emit_item.last = 1'b1;
		case (cmd)
			CMD_DONE: begin
				emit = out_free;
				emit_item.status = st_q;
			end
			CMD_T_LEN: begin
				emit = pend_v_q && out_free;
				emit_item.match_found = 1'b1;
				emit_item.word_id = wid_x[3:0];
				emit_item.start_pos = pend_pos_q;
				emit_item.last = 1'b0;
			end
			CMD_T_END: begin
				emit = out_free;
				emit_item.match_found = pend_v_q;
				emit_item.word_id = pend_v_q ? wid_x[3:0] : 4'd0;
				emit_item.start_pos = pend_v_q ? pend_pos_q : 32'd0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q <= FUNC_NONE; sym_q <= '0; eow_q <= 1'b0; st_q <= ST_OK;
			nc_q <= NCW'(1); wc_q <= '0; ins_q <= '0; plen_q <= '0;
			nxt_q <= '0; fresh_q <= 1'b0; failed_q <= 1'b0; built_q <= 1'b0;
			cur_q <= '0; pos_q <= '0; clr_q <= '0;
			cur_b_q <= '0; c_q <= '0; ch_q <= '0; f_q <= '0;
			head_q <= '0; tail_q <= '0; n_q <= '0; w_q <= '0;
			pend_v_q <= 1'b0; pend_w_q <= '0; pend_pos_q <= '0;
			res_v_q <= 1'b0; res_q <= '0;
		end else begin
			if (emit) begin
				res_v_q <= 1'b1;
				res_q <= emit_item;
			end else if (!result_stall) begin
				res_v_q <= 1'b0;
			end
			case (cmd)
				CMD_CLEAR: clr_q <= clr_q + CW'(1);
				CMD_LOAD: begin
					func_q <= item.func; sym_q <= sym_in; eow_q <= item.end_of_word;
					st_q <= ST_OK; cur_b_q <= '0; c_q <= '0;
					head_q <= '0; tail_q <= '0; pend_v_q <= 1'b0; w_q <= '0;
					if (item.func == FUNC_TEXT && item.start_of_text) begin
						cur_q <= '0; pos_q <= '0;
					end
				end
				CMD_PAT_CHK: begin
					if (built_q) st_q <= ST_AFTER_BUILD;
					else if (!failed_q && wc_q == WCW'(MAX_WORDS)) begin
						st_q <= ST_WORDS_FULL; failed_q <= 1'b1;
					end
				end
				CMD_PAT_WR: begin
					if (stat.pat_nofit) begin
						st_q <= ST_NODES_FULL; failed_q <= 1'b1;
					end else begin
						nxt_q <= rd0 ? NW'(nc_q) : child_rd;
						fresh_q <= rd0;
						if (rd0) nc_q <= nc_q + NCW'(1);
					end
				end
				CMD_PAT_OWN: begin
					ins_q <= nxt_q;
					plen_q <= plen_q + NW'(1);
					if (eow_q) wc_q <= wc_q + WCW'(1);
				end
				CMD_DONE: begin
					if (out_free && func_q == FUNC_PATTERN && eow_q) begin
						ins_q <= '0; plen_q <= '0; failed_q <= 1'b0;
					end
				end
				CMD_B_CH: begin
					ch_q <= child_rd;
					if (rd0 || stat.cur_b_zero) c_q <= c_q + SW'(1);
					if (!rd0 && stat.cur_b_zero) tail_q <= tail_q + NCW'(1);
				end
				CMD_B_F1: f_q <= fail_rd;
				CMD_B_F2: begin
					if (fix_ok) begin
						c_q <= c_q + SW'(1);
						tail_q <= tail_q + NCW'(1);
					end
				end
				CMD_B_NEXT: if (stat.q_empty) built_q <= 1'b1;
				CMD_B_POP: begin
					cur_b_q <= q_rd; head_q <= head_q + NCW'(1); c_q <= '0;
				end
				CMD_T_CK: begin
					if (stat.cur_zero || !rd0) begin
						cur_q <= child_rd; n_q <= child_rd;
					end
				end
				CMD_T_FL: cur_q <= built_q ? fail_rd : '0;
				CMD_T_NRD: w_q <= '0;
				CMD_T_SCAN: if (!stat.own_bit) w_q <= w_q + WW'(1);
				CMD_T_LEN: begin
					if (!stat.pend_wait) begin
						pend_v_q <= 1'b1; pend_w_q <= w_q; pend_pos_q <= match_pos;
						w_q <= w_q + WW'(1);
					end
				end
				CMD_T_NXT: n_q <= built_q ? fail_rd : '0;
				CMD_T_END: if (out_free && pos_q != '1) pos_q <= pos_q + 32'd1;
				default: begin
				end
			endcase
		end
	end

	assign result_valid = res_v_q;
	assign result = res_q;

endmodule

>>> rtl/msm_chk.sv
module msm_chk import msm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed under stall");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second transaction taken while busy");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_OK |-> result.last && !result.match_found)
		else $error("error status on a match result");

	a_nomatch_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.match_found |-> result.last && result.word_id == 4'd0)
		else $error("empty result not final");

endmodule

bind multi_pattern_string_matcher msm_chk u_msm_chk (.*);

>>> sim/tb.sv
module tb;
	import msm_pkg::*;

	localparam int NODES = MAX_NODES_D;
	localparam int SYMS  = ALPHABET_D;
	localparam int WORDS = MAX_WORDS_D;

	class match_scoreboard;
		int unsigned     child[NODES*SYMS];
		int unsigned     fail_lk[NODES];
		bit [WORDS-1:0]  own[NODES];
		int unsigned     wlen[WORDS];
		int unsigned     node_count = 1;
		int unsigned     word_count = 0;
		int unsigned     ins_node = 0;
		int unsigned     plen = 0;
		bit              word_bad = 0;
		bit              built = 0;
		int unsigned     cur_node = 0;
		bit [31:0]       tpos = 0;
		out_item_t       expected_matches[$];
		int              errors = 0;

		function void push(status_t st, bit f, int unsigned id, bit [31:0] pos, bit l);
			out_item_t r;
			r.status = st;
			r.match_found = f;
			r.word_id = id[3:0];
			r.start_pos = pos;
			r.last = l;
			expected_matches = {expected_matches, r};
		endfunction

		function void build_links();
			int unsigned q[$];
			int unsigned cur, ch, f;
			for (int c = 0; c < SYMS; c++) begin
				ch = child[c];
				if (ch != 0) begin
					fail_lk[ch] = 0;
					q = {q, ch};
				end
			end
			while (q.size() > 0) begin
				cur = q.pop_front();
				for (int c = 0; c < SYMS; c++) begin
					ch = child[cur*SYMS+c];
					if (ch != 0) begin
						f = fail_lk[cur];
						while (f != 0 && child[f*SYMS+c] == 0)
							f = fail_lk[f];
						fail_lk[ch] = child[f*SYMS+c];
						q = {q, ch};
					end
				end
			end
			built = 1;
		endfunction

		function void scan_text(int unsigned sym, bit sot);
			out_item_t hits[$];
			out_item_t r;
			bit [31:0] i;
			int unsigned n, k, len;
			k = 0;
			if (sot) begin
				cur_node = 0;
				tpos = 0;
			end
			i = tpos;
			while (cur_node != 0 && child[cur_node*SYMS+sym] == 0)
				cur_node = fail_lk[cur_node];
			cur_node = child[cur_node*SYMS+sym];
			n = cur_node;
			while (n != 0) begin
				for (int w = 0; w < word_count; w++) begin
					if (own[n][w] && k < WORDS) begin
						len = wlen[w];
						r.status = ST_OK;
						r.match_found = 1;
						r.word_id = w[3:0];
						if (64'(len) > 64'(i) + 1 && i != 32'hFFFFFFFF)
							r.start_pos = 0;
						else
							r.start_pos = i - len[31:0] + 32'd1;
						r.last = 0;
						hits = {hits, r};
						k++;
					end
				end
				n = fail_lk[n];
			end
			if (tpos != 32'hFFFFFFFF)
				tpos++;
			if (k == 0) begin
				push(ST_OK, 0, 0, 0, 1);
			end else begin
				hits[k-1].last = 1;
				foreach (hits[j])
					expected_matches = {expected_matches, hits[j]};
			end
		endfunction

		function void note_item(in_item_t x);
			int unsigned sym, nxt;
			status_t st;
			sym = (x.symbol >= SYMS) ? SYMS - 1 : x.symbol;
			case (x.func)
				FUNC_PATTERN: begin
					st = ST_OK;
					if (built) begin
						st = ST_AFTER_BUILD;
					end else if (!word_bad) begin
						if (word_count >= WORDS) begin
							st = ST_WORDS_FULL;
							word_bad = 1;
						end else begin
							nxt = child[ins_node*SYMS+sym];
							if (nxt == 0) begin
								if (node_count >= NODES) begin
									st = ST_NODES_FULL;
									word_bad = 1;
								end else begin
									nxt = node_count;
									node_count++;
									child[ins_node*SYMS+sym] = nxt;
								end
							end
							if (!word_bad) begin
								ins_node = nxt;
								plen++;
								if (x.end_of_word) begin
									own[ins_node][word_count] = 1;
									wlen[word_count] = plen;
									word_count++;
								end
							end
						end
					end
					if (x.end_of_word) begin
						ins_node = 0;
						plen = 0;
						word_bad = 0;
					end
					push(st, 0, 0, 0, 1);
				end
				FUNC_BUILD: begin
					build_links();
					push(ST_OK, 0, 0, 0, 1);
				end
				FUNC_TEXT: scan_text(sym, x.start_of_text);
				default: push(ST_OK, 0, 0, 0, 1);
			endcase
		endfunction

		function void check_result(out_item_t r);
			out_item_t e;
			if (expected_matches.size() == 0) begin
				$display("%0t: unexpected transaction %p", $time, r);
				errors++;
			end else begin
				e = expected_matches.pop_front();
				if (r.status !== e.status || r.match_found !== e.match_found ||
						r.word_id !== e.word_id || r.start_pos !== e.start_pos ||
						r.last !== e.last) begin
					$display("%0t: expected %p actual %p", $time, e, r);
					errors++;
				end
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_item_t  item;
	logic      result_valid;
	logic      result_stall;
	out_item_t result;

	match_scoreboard sb;
	bit calm_in, calm_out;
	int stall_left;

	multi_pattern_string_matcher uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100000000;
		$display("Mismatches found");
		$finish;
	end

	function automatic int pick_gap(bit calm);
		int p;
		p = $urandom_range(0, 99);
		if (calm || p < 65)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send(func_t f, int unsigned sym, bit eow, bit sot);
		in_item_t x;
		int gap;
		x.func = f;
		x.symbol = sym[4:0];
		x.end_of_word = eow;
		x.start_of_text = sot;
		if ($urandom_range(0, 49) == 0)
			calm_in = ~calm_in;
		gap = pick_gap(calm_in);
		if (gap > 0) begin
			item_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		item <= x;
		item_valid <= 1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_item(x);
	endtask

	function automatic int unsigned rand_sym();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
	endfunction

	task automatic put_word(int len);
		for (int j = 0; j < len; j++) begin
			if ($urandom_range(0, 19) == 0)
				send(FUNC_TEXT, rand_sym(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			send(FUNC_PATTERN, rand_sym(), j == len - 1, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic put_fixed(int unsigned w[$]);
		foreach (w[j])
			send(FUNC_PATTERN, w[j], j == w.size() - 1, 0);
	endtask

	task automatic put_text(int unsigned w[$]);
		foreach (w[j])
			send(FUNC_TEXT, w[j], 0, j == 0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				sb.check_result(result);
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result_stall <= 1;
			end else begin
				if ($urandom_range(0, 99) == 0)
					calm_out <= ~calm_out;
				stall_left <= pick_gap(calm_out);
				result_stall <= 0;
			end
		end
	end

	initial begin
		int p;
		sb = new();
		arst_n = 0;
		item_valid = 0;
		item = '0;
		result_stall = 0;
		stall_left = 0;
		calm_in = 0;
		calm_out = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		put_fixed('{7, 4});
		put_fixed('{18, 7, 4});
		put_fixed('{7, 8, 18});
		put_fixed('{7, 4, 17, 18});
		put_fixed('{7, 4});
		put_fixed('{31});
		put_text('{18, 7, 4});
		send(FUNC_NONE, 31, 1, 1);

		while (sb.node_count < NODES && sb.word_count < 15)
			put_word($urandom_range(10, 30));
		put_word(30);
		while (sb.word_count < WORDS)
			put_word($urandom_range(1, 2));
		put_word(2);

		send(FUNC_BUILD, 0, 0, 0);
		put_text('{20, 18, 7, 4, 17, 18});
		send(FUNC_TEXT, 31, 1, 0);
		send(FUNC_PATTERN, 3, 1, 0);
		send(FUNC_BUILD, 31, 1, 1);

		for (int n = 0; n < 200; n++) begin
			p = $urandom_range(0, 99);
			if (p < 86)
				send(FUNC_TEXT, rand_sym(), 1'($urandom_range(0, 1)),
					$urandom_range(0, 29) == 0);
			else if (p < 92)
				send(FUNC_NONE, $urandom_range(0, 31), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			else if (p < 98)
				send(FUNC_PATTERN, $urandom_range(0, 31), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			else
				send(FUNC_BUILD, $urandom_range(0, 31), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
		end
		item_valid <= 0;

		while (sb.expected_matches.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
